[sv/rdsh_pkg.sv]
package rdsh_pkg;

    localparam int COORD_W = 18;
    localparam int DIR_W   = 11;
    localparam int PROD_W  = 29;
    localparam int CROSS_W = 30;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIR_W-1:0]   dir_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;

    localparam coord_t HALF_CELL = coord_t'(128);
    localparam coord_t FULL_CELL = coord_t'(256);

    typedef struct packed {
        dir_t   dx;
        dir_t   dy;
        coord_t dax;
        coord_t day;
        coord_t dbx;
        coord_t dby;
        coord_t px;
        coord_t py;
        coord_t ex;
        coord_t ey;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        logic   side;
    } geom_t;

    typedef struct packed {
        prod_t p1a;
        prod_t p1b;
        prod_t p2a;
        prod_t p2b;
        logic  box_a;
        logic  box_b;
        logic  on_p;
        logic  on_e;
    } prod_set_t;

endpackage

[sv/ray_door_segment_hit_test_top.sv]
// Ray against door hit test, one test per transaction.
// Input channel: a transaction is taken at a rising edge where start is high and
// busy is low. Busy is always low, so a new transaction may be issued every cycle.
// The transaction carries the viewer position, the ray direction, the door cell
// and the door orientation.
// Result channel: done is high for exactly one cycle with hit valid beside it.
// A transaction passes the coordinate setup, multiplier and sign decision registers
// in that order, and done is the valid bit of the last of them.
// Throughput is one transaction per cycle; each of the three register stages
// (coordinate setup, four multipliers, sign decision) takes a new one every cycle.
// Results leave in the order the transactions arrived.
// Reset clears the stage valid bits, so no done is raised for anything that
// entered before reset. The receiver cannot stall; it must take each result in
// the cycle that done is high.
module ray_door_segment_hit_test_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        pos_x,
    input  logic [15:0]        pos_y,
    input  logic signed [10:0] ray_dir_x,
    input  logic signed [10:0] ray_dir_y,
    input  logic [7:0]         door_cell_x,
    input  logic [7:0]         door_cell_y,
    input  logic               door_side,
    output logic               done,
    output logic               hit
);
    import rdsh_pkg::*;

    logic      geom_valid;
    geom_t     geom;
    logic      prod_valid;
    prod_set_t prods;

    assign busy = 1'b0;

    rdsh_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .ray_dir_x   (ray_dir_x),
        .ray_dir_y   (ray_dir_y),
        .door_cell_x (door_cell_x),
        .door_cell_y (door_cell_y),
        .door_side   (door_side),
        .out_valid   (geom_valid),
        .out_geom    (geom)
    );

    rdsh_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .in_geom   (geom),
        .out_valid (prod_valid),
        .out_prod  (prods)
    );

    rdsh_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_prod   (prods),
        .out_valid (done),
        .out_hit   (hit)
    );

endmodule

[sv/rdsh_prep.sv]
module rdsh_prep (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [15:0]           pos_x,
    input  logic [15:0]           pos_y,
    input  logic signed [10:0]    ray_dir_x,
    input  logic signed [10:0]    ray_dir_y,
    input  logic [7:0]            door_cell_x,
    input  logic [7:0]            door_cell_y,
    input  logic                  door_side,
    output logic                  out_valid,
    output rdsh_pkg::geom_t       out_geom
);
    import rdsh_pkg::*;

    logic   valid_reg;
    geom_t  geom_reg;
    geom_t  geom_next;
    coord_t px;
    coord_t py;
    coord_t cx;
    coord_t cy;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;

    always_comb
    begin
        px = coord_t'({2'b00, pos_x});
        py = coord_t'({2'b00, pos_y});
        cx = coord_t'({2'b00, door_cell_x, 8'h00});
        cy = coord_t'({2'b00, door_cell_y, 8'h00});
        if (door_side)
        begin
            ax = cx + HALF_CELL;
            ay = cy;
            bx = cx + HALF_CELL;
            by = cy + FULL_CELL;
        end
        else
        begin
            ax = cx;
            ay = cy + HALF_CELL;
            bx = cx + FULL_CELL;
            by = cy + HALF_CELL;
        end
        geom_next.dx   = ray_dir_x;
        geom_next.dy   = ray_dir_y;
        geom_next.dax  = ax - px;
        geom_next.day  = ay - py;
        geom_next.dbx  = bx - px;
        geom_next.dby  = by - py;
        geom_next.px   = px;
        geom_next.py   = py;
        geom_next.ex   = px + coord_t'(ray_dir_x);
        geom_next.ey   = py + coord_t'(ray_dir_y);
        geom_next.ax   = ax;
        geom_next.ay   = ay;
        geom_next.bx   = bx;
        geom_next.by   = by;
        geom_next.side = door_side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        geom_reg <= geom_next;
    end

    assign out_valid = valid_reg;
    assign out_geom  = geom_reg;

endmodule

[sv/rdsh_mul.sv]
module rdsh_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  rdsh_pkg::geom_t       in_geom,
    output logic                  out_valid,
    output rdsh_pkg::prod_set_t   out_prod
);
    import rdsh_pkg::*;

    logic      valid_reg;
    prod_set_t prod_reg;
    prod_set_t prod_next;

    always_comb
    begin
        prod_next.p1a = prod_t'(in_geom.dx) * prod_t'(in_geom.day);
        prod_next.p1b = prod_t'(in_geom.dy) * prod_t'(in_geom.dax);
        prod_next.p2a = prod_t'(in_geom.dx) * prod_t'(in_geom.dby);
        prod_next.p2b = prod_t'(in_geom.dy) * prod_t'(in_geom.dbx);

        prod_next.box_a =
            ((in_geom.ax >= in_geom.px && in_geom.ax <= in_geom.ex) ||
             (in_geom.ax >= in_geom.ex && in_geom.ax <= in_geom.px)) &&
            ((in_geom.ay >= in_geom.py && in_geom.ay <= in_geom.ey) ||
             (in_geom.ay >= in_geom.ey && in_geom.ay <= in_geom.py));
        prod_next.box_b =
            ((in_geom.bx >= in_geom.px && in_geom.bx <= in_geom.ex) ||
             (in_geom.bx >= in_geom.ex && in_geom.bx <= in_geom.px)) &&
            ((in_geom.by >= in_geom.py && in_geom.by <= in_geom.ey) ||
             (in_geom.by >= in_geom.ey && in_geom.by <= in_geom.py));

        // The door is axis aligned, so a zero cross product against it means the
        // point sits on the door's line and only the span along the door remains.
        if (in_geom.side)
        begin
            prod_next.on_p = (in_geom.px == in_geom.ax) &&
                             (in_geom.py >= in_geom.ay) && (in_geom.py <= in_geom.by);
            prod_next.on_e = (in_geom.ex == in_geom.ax) &&
                             (in_geom.ey >= in_geom.ay) && (in_geom.ey <= in_geom.by);
        end
        else
        begin
            prod_next.on_p = (in_geom.py == in_geom.ay) &&
                             (in_geom.px >= in_geom.ax) && (in_geom.px <= in_geom.bx);
            prod_next.on_e = (in_geom.ey == in_geom.ay) &&
                             (in_geom.ex >= in_geom.ax) && (in_geom.ex <= in_geom.bx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;

endmodule

[sv/rdsh_decide.sv]
module rdsh_decide (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  rdsh_pkg::prod_set_t   in_prod,
    output logic                  out_valid,
    output logic                  out_hit
);
    import rdsh_pkg::*;

    logic   valid_reg;
    logic   hit_reg;
    logic   hit_next;
    cross_t d1;
    cross_t d2;

    always_comb
    begin
        d1 = cross_t'(in_prod.p1a) - cross_t'(in_prod.p1b);
        d2 = cross_t'(in_prod.p2a) - cross_t'(in_prod.p2b);
        hit_next = ((d1 > 0) && (d2 < 0)) || ((d1 < 0) && (d2 > 0)) ||
                   ((d1 == 0) && in_prod.box_a) ||
                   ((d2 == 0) && in_prod.box_b) ||
                   in_prod.on_p || in_prod.on_e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign out_valid = valid_reg;
    assign out_hit   = hit_reg;

endmodule

[sv/rdsh_checker.sv]
module rdsh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [15:0] pos_x,
    input logic [15:0] pos_y,
    input logic [10:0] ray_dir_x,
    input logic [10:0] ray_dir_y,
    input logic [7:0]  door_cell_x,
    input logic [7:0]  door_cell_y,
    input logic        door_side,
    input logic        done,
    input logic        hit
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("Accepted transaction produced no result after three cycles.");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##3 !done)
        else $error("Result strobe raised without an accepted transaction.");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Block reported busy while delivering results.");

    a_point_on_door: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && door_side && ray_dir_x == 11'd0 && ray_dir_y == 11'd0 &&
         pos_x[15:8] == door_cell_x && pos_x[7:0] == 8'h80 &&
         pos_y[15:8] == door_cell_y) |-> ##3 (done && hit))
        else $error("Viewer standing on a vertical door was not reported as a hit.");

endmodule

bind ray_door_segment_hit_test_top rdsh_checker u_rdsh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .ray_dir_x   (ray_dir_x),
    .ray_dir_y   (ray_dir_y),
    .door_cell_x (door_cell_x),
    .door_cell_y (door_cell_y),
    .door_side   (door_side),
    .done        (done),
    .hit         (hit)
);
